FILE: src/ogw_pkg.sv
package ogw_pkg;

  // Queue between classifier and pose stage
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAX_SPEED    = 3'd0;
  localparam logic [2:0] CFG_STILL_SPEED  = 3'd1;
  localparam logic [2:0] CFG_STILL_FRAMES = 3'd2;
  localparam logic [2:0] CFG_JUMP_MOVING  = 3'd3;
  localparam logic [2:0] CFG_JUMP_STILL   = 3'd4;

  // Register reset values
  localparam logic [30:0] RST_MAX_SPEED    = 31'd327680;
  localparam logic [30:0] RST_STILL_SPEED  = 31'd3277;
  localparam logic [7:0]  RST_STILL_FRAMES = 8'd5;
  localparam logic [30:0] RST_JUMP_MOVING  = 31'd65536;
  localparam logic [30:0] RST_JUMP_STILL   = 31'd9830;

  // Reject status codes
  localparam logic [1:0] ST_NONE  = 2'b00;
  localparam logic [1:0] ST_SPEED = 2'b01;
  localparam logic [1:0] ST_JUMP  = 2'b10;

  localparam logic signed [15:0] QUAT_ONE = 16'sd16384;
  localparam logic [7:0]         COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_quat_w;
    logic signed [15:0] out_quat_x;
    logic signed [15:0] out_quat_y;
    logic signed [15:0] out_quat_z;
    logic [1:0]         reject_status;
    logic               is_still;
  } out_item_t;

  // Registered limits, squared where they are compared against squares
  typedef struct packed {
    logic [61:0] max2;
    logic [61:0] still2;
    logic [61:0] jmov2;
    logic [61:0] jstill2;
    logic [7:0]  still_frames;
  } cfg_sq_t;

  // Classified sample as it waits for the pose stage
  typedef struct packed {
    in_item_t    item;
    logic [63:0] sp2;
    logic        over_max;
    logic        in_slow;
  } q_entry_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (32'd0 - $unsigned(v)) : $unsigned(v);
    return r;
  endfunction

endpackage

FILE: src/ogw_cfg.sv
module ogw_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [30:0]       cfg_wdata,
  output ogw_pkg::cfg_sq_t  cfg
);
  import ogw_pkg::*;

  logic [30:0] max_speed_r, still_speed_r, jump_moving_r, jump_still_r;
  logic [7:0]  still_frames_r;
  logic [61:0] max2_r, still2_r, jmov2_r, jstill2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r    <= RST_MAX_SPEED;
      still_speed_r  <= RST_STILL_SPEED;
      still_frames_r <= RST_STILL_FRAMES;
      jump_moving_r  <= RST_JUMP_MOVING;
      jump_still_r   <= RST_JUMP_STILL;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MAX_SPEED:    max_speed_r    <= cfg_wdata;
        CFG_STILL_SPEED:  still_speed_r  <= cfg_wdata;
        CFG_STILL_FRAMES: still_frames_r <= cfg_wdata[7:0];
        CFG_JUMP_MOVING:  jump_moving_r  <= cfg_wdata;
        CFG_JUMP_STILL:   jump_still_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Squares are registered; user must write only while idle, not enforced
  always_ff @(posedge clk) begin
    max2_r    <= max_speed_r * max_speed_r;
    still2_r  <= still_speed_r * still_speed_r;
    jmov2_r   <= jump_moving_r * jump_moving_r;
    jstill2_r <= jump_still_r * jump_still_r;
  end

  assign cfg.max2         = max2_r;
  assign cfg.still2       = still2_r;
  assign cfg.jmov2        = jmov2_r;
  assign cfg.jstill2      = jstill2_r;
  assign cfg.still_frames = still_frames_r;

endmodule

FILE: src/ogw_front.sv
module ogw_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ogw_pkg::in_item_t         in_data,
  input  ogw_pkg::cfg_sq_t          cfg,
  input  logic [ogw_pkg::QAW:0]     q_count,
  output logic                      push,
  output ogw_pkg::q_entry_t         push_data
);
  import ogw_pkg::*;

  logic        a_valid_r, b_valid_r, c_valid_r;
  in_item_t    a_item_r, b_item_r;
  logic [62:0] b_sqx_r, b_sqy_r, b_sqz_r;
  q_entry_t    c_entry_r, c_entry_nxt;
  logic [QAW+1:0] occupancy;
  logic        accept;
  logic [63:0] sum;
  logic [31:0] ax, ay, az;
  logic [63:0] sqx, sqy, sqz;

  // Reserve a queue slot for every transaction still in the pipeline
  assign occupancy = (QAW+2)'(a_valid_r) + (QAW+2)'(b_valid_r) + (QAW+2)'(c_valid_r)
                   + (QAW+2)'(q_count);
  assign in_stall  = occupancy >= (QAW+2)'(QDEPTH);
  assign accept    = in_valid && !in_stall;

  assign ax = abs32(a_item_r.vel_x);
  assign ay = abs32(a_item_r.vel_y);
  assign az = abs32(a_item_r.vel_z);

  assign sqx = ax * ax;
  assign sqy = ay * ay;
  assign sqz = az * az;

  always_comb begin
    sum = {1'b0, b_sqx_r} + {1'b0, b_sqy_r} + {1'b0, b_sqz_r};
    c_entry_nxt.item     = b_item_r;
    c_entry_nxt.sp2      = sum;
    c_entry_nxt.over_max = sum > {2'b00, cfg.max2};
    c_entry_nxt.in_slow  = sum < {2'b00, cfg.still2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) a_item_r <= in_data;
    b_item_r  <= a_item_r;
    b_sqx_r   <= sqx[62:0];
    b_sqy_r   <= sqy[62:0];
    b_sqz_r   <= sqz[62:0];
    c_entry_r <= c_entry_nxt;
  end

  assign push      = c_valid_r;
  assign push_data = c_entry_r;

endmodule

FILE: src/ogw_fifo.sv
module ogw_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ogw_pkg::q_entry_t     push_data,
  input  logic                  pop,
  output ogw_pkg::q_entry_t     head,
  output logic                  empty,
  output logic [ogw_pkg::QAW:0] count
);
  import ogw_pkg::*;

  q_entry_t       mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = count_r == '0;
  assign count = count_r;

endmodule

FILE: src/ogw_back.sv
module ogw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ogw_pkg::q_entry_t  head,
  input  logic               q_empty,
  output logic               pop,
  input  ogw_pkg::cfg_sq_t   cfg,
  output logic               out_valid,
  input  logic               out_stall,
  output ogw_pkg::out_item_t out_data
);
  import ogw_pkg::*;

  // Held state
  logic signed [31:0] held_vx_r, held_vy_r, held_vz_r;
  logic [63:0]        held_sp2_r;
  logic               vel_valid_r;
  logic signed [31:0] held_px_r, held_py_r, held_pz_r;
  logic signed [15:0] held_qw_r, held_qx_r, held_qy_r, held_qz_r;
  logic               pose_valid_r;
  logic [7:0]         slow_count_r;

  // Jump stage
  logic        s_valid_r, s_big_r, s_still_r, s_vrej_r;
  in_item_t    s_item_r;
  logic [61:0] s_sqx_r, s_sqy_r, s_sqz_r;

  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        fire1, fire2, vrej, slow, still, jump;
  logic [7:0]  slow_count_nxt;
  logic [32:0] dx, dy, dz, adx, ady, adz;
  logic        big;
  logic [63:0] jsum;
  logic [61:0] lim2;
  in_item_t    s_item_nxt;

  // The pose check needs the held pose of the previous transaction, so one
  // transaction is in this stage at a time
  assign fire1 = !q_empty && !s_valid_r;
  assign fire2 = s_valid_r && (!out_valid_r || !out_stall);
  assign pop   = fire1;

  always_comb begin
    vrej = vel_valid_r && head.over_max;
    slow = vrej ? (held_sp2_r < {2'b00, cfg.still2}) : head.in_slow;
    if (!slow) begin
      slow_count_nxt = '0;
    end else if (slow_count_r == COUNT_MAX) begin
      slow_count_nxt = COUNT_MAX;
    end else begin
      slow_count_nxt = slow_count_r + 8'd1;
    end
    still = slow_count_nxt >= cfg.still_frames;

    dx  = {head.item.pos_x[31], head.item.pos_x} - {held_px_r[31], held_px_r};
    dy  = {head.item.pos_y[31], head.item.pos_y} - {held_py_r[31], held_py_r};
    dz  = {head.item.pos_z[31], head.item.pos_z} - {held_pz_r[31], held_pz_r};
    adx = dx[32] ? (33'd0 - dx) : dx;
    ady = dy[32] ? (33'd0 - dy) : dy;
    adz = dz[32] ? (33'd0 - dz) : dz;
    big = (adx[32:31] != 2'b00) || (ady[32:31] != 2'b00) || (adz[32:31] != 2'b00);

    s_item_nxt = head.item;
    if (vrej) begin
      s_item_nxt.vel_x = held_vx_r;
      s_item_nxt.vel_y = held_vy_r;
      s_item_nxt.vel_z = held_vz_r;
    end
  end

  always_comb begin
    jsum = {2'b00, s_sqx_r} + {2'b00, s_sqy_r} + {2'b00, s_sqz_r};
    lim2 = s_still_r ? cfg.jstill2 : cfg.jmov2;
    jump = pose_valid_r && (s_big_r || (jsum > {2'b00, lim2}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vx_r    <= '0;
      held_vy_r    <= '0;
      held_vz_r    <= '0;
      held_sp2_r   <= '0;
      vel_valid_r  <= 1'b0;
      slow_count_r <= '0;
      held_px_r    <= '0;
      held_py_r    <= '0;
      held_pz_r    <= '0;
      held_qw_r    <= QUAT_ONE;
      held_qx_r    <= '0;
      held_qy_r    <= '0;
      held_qz_r    <= '0;
      pose_valid_r <= 1'b0;
      s_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire1) begin
        slow_count_r <= slow_count_nxt;
        if (!vrej) begin
          held_vx_r   <= head.item.vel_x;
          held_vy_r   <= head.item.vel_y;
          held_vz_r   <= head.item.vel_z;
          held_sp2_r  <= head.sp2;
          vel_valid_r <= 1'b1;
        end
      end
      if (fire2 && !jump) begin
        held_px_r    <= s_item_r.pos_x;
        held_py_r    <= s_item_r.pos_y;
        held_pz_r    <= s_item_r.pos_z;
        held_qw_r    <= s_item_r.quat_w;
        held_qx_r    <= s_item_r.quat_x;
        held_qy_r    <= s_item_r.quat_y;
        held_qz_r    <= s_item_r.quat_z;
        pose_valid_r <= 1'b1;
      end
      if (fire1) begin
        s_valid_r <= 1'b1;
      end else if (fire2) begin
        s_valid_r <= 1'b0;
      end
      if (fire2) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire1) begin
      s_item_r  <= s_item_nxt;
      s_big_r   <= big;
      s_still_r <= still;
      s_vrej_r  <= vrej;
      s_sqx_r   <= adx[30:0] * adx[30:0];
      s_sqy_r   <= ady[30:0] * ady[30:0];
      s_sqz_r   <= adz[30:0] * adz[30:0];
    end
    if (fire2) begin
      out_data_r.out_vel_x     <= s_item_r.vel_x;
      out_data_r.out_vel_y     <= s_item_r.vel_y;
      out_data_r.out_vel_z     <= s_item_r.vel_z;
      out_data_r.out_pos_x     <= jump ? held_px_r : s_item_r.pos_x;
      out_data_r.out_pos_y     <= jump ? held_py_r : s_item_r.pos_y;
      out_data_r.out_pos_z     <= jump ? held_pz_r : s_item_r.pos_z;
      out_data_r.out_quat_w    <= jump ? held_qw_r : s_item_r.quat_w;
      out_data_r.out_quat_x    <= jump ? held_qx_r : s_item_r.quat_x;
      out_data_r.out_quat_y    <= jump ? held_qy_r : s_item_r.quat_y;
      out_data_r.out_quat_z    <= jump ? held_qz_r : s_item_r.quat_z;
      out_data_r.reject_status <= (s_vrej_r ? ST_SPEED : ST_NONE) | (jump ? ST_JUMP : ST_NONE);
      out_data_r.is_still      <= s_still_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/odometry_glitch_watchdog_core.sv
// Odometry glitch watchdog.
// Input channel in_valid/in_stall/in_data carries one odometry sample per
// transaction (velocity, position, quaternion); the result channel
// out_valid/out_stall/out_data returns exactly one result per sample, in order.
// A transaction moves on a rising edge with valid high and stall low.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (0 max speed,
// 1 still speed, 2 still frames, 3 moving jump limit, 4 still jump limit);
// other indexes are ignored. Write only while no sample is in flight.
// A sample passes the classifier, the queue, the jump stage and the result
// register. The pose check loop sets the rate: the squared jump against the
// held pose must be resolved before the next sample can be compared, so the
// jump stage takes no new sample until the last one has left it. A three-stage
// classifier computes the speed squares ahead of it and feeds a 4-entry queue.
// When out_stall is high a pending result holds; the classifier keeps
// taking samples until the queue and pipeline are full, then raises in_stall.
// Reset (rst_n low, synchronous) restores default limits, clears held
// velocity and pose, sets the held quaternion to identity and empties the
// pipeline.
module odometry_glitch_watchdog_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ogw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ogw_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [30:0]        cfg_wdata
);
  import ogw_pkg::*;

  cfg_sq_t      cfg;
  logic         push, pop, q_empty;
  q_entry_t     push_data, head;
  logic [QAW:0] q_count;

  ogw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ogw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  ogw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .count     (q_count)
  );

  ogw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/tb_odometry_glitch_watchdog_core.sv
module tb_odometry_glitch_watchdog_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ogw_pkg::*;

  localparam int          SETTLE_CYCLES = 12;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam logic [2:0]  CFG_SPARE     = 3'd5;
  localparam logic [30:0] LIM_TOP       = 31'h7FFF_FFFF;
  localparam longint      STEP_CAP      = 64'd1 << 20;

  typedef enum int {K_CRUISE, K_STILL, K_SPIKE, K_JUMP, K_EDGE, K_NOISE} sample_kind_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_idx   = CFG_MAX_SPEED;
  logic [30:0] cfg_wdata = '0;

  odometry_glitch_watchdog_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Watchdog copy: limits, held sample and slow-frame run
  logic [30:0] max_speed_r, still_speed_r, jump_moving_r, jump_still_r;
  logic [7:0]  still_frames_r, slow_run;
  in_item_t    held;
  logic        vel_held_ok, pose_held_ok;

  in_item_t  sample_q[$];
  out_item_t odom_expected_q[$];
  int        queued_count = 0;
  int        taken_count  = 0;
  int        fail_count   = 0;
  int        cycle_count  = 0;
  int        send_gap     = 0;
  int        stall_left   = 0;
  bit        in_fire      = 1'b0;
  bit        idle_on      = 1'b0;
  longint    trail[3];

  function automatic logic [63:0] axis_sq(logic signed [31:0] x);
    longint     a;
    logic [63:0] u;
    a = longint'(x);
    if (a < 0) a = -a;
    u = a;
    return u * u;
  endfunction

  function automatic logic [63:0] speed_sq(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z);
    return axis_sq(x) + axis_sq(y) + axis_sq(z);
  endfunction

  function automatic logic [63:0] limit_sq(logic [30:0] v);
    logic [63:0] u;
    u = {33'd0, v};
    return u * u;
  endfunction

  function automatic void clear_watchdog();
    max_speed_r    = RST_MAX_SPEED;
    still_speed_r  = RST_STILL_SPEED;
    still_frames_r = RST_STILL_FRAMES;
    jump_moving_r  = RST_JUMP_MOVING;
    jump_still_r   = RST_JUMP_STILL;
    held           = '0;
    held.quat_w    = QUAT_ONE;
    vel_held_ok    = 1'b0;
    pose_held_ok   = 1'b0;
    slow_run       = '0;
  endfunction

  function automatic void set_limit(logic [2:0] idx, logic [30:0] v);
    case (idx)
      CFG_MAX_SPEED:    max_speed_r    = v;
      CFG_STILL_SPEED:  still_speed_r  = v;
      CFG_STILL_FRAMES: still_frames_r = v[7:0];
      CFG_JUMP_MOVING:  jump_moving_r  = v;
      CFG_JUMP_STILL:   jump_still_r   = v;
      default: ;
    endcase
  endfunction

  function automatic out_item_t judge_sample(in_item_t s);
    out_item_t          r;
    logic [63:0]        spd2, jump2, lim2, a;
    longint             d;
    logic               far;
    logic signed [31:0] now_pos[3];
    logic signed [31:0] old_pos[3];
    int                 i;
    r = '0;
    r.out_vel_x = s.vel_x;
    r.out_vel_y = s.vel_y;
    r.out_vel_z = s.vel_z;
    r.reject_status = ST_NONE;
    spd2 = speed_sq(s.vel_x, s.vel_y, s.vel_z);
    if (vel_held_ok && spd2 > limit_sq(max_speed_r)) begin
      r.reject_status = r.reject_status | ST_SPEED;
      r.out_vel_x = held.vel_x;
      r.out_vel_y = held.vel_y;
      r.out_vel_z = held.vel_z;
      spd2 = speed_sq(held.vel_x, held.vel_y, held.vel_z);
    end else begin
      held.vel_x  = s.vel_x;
      held.vel_y  = s.vel_y;
      held.vel_z  = s.vel_z;
      vel_held_ok = 1'b1;
    end
    if (spd2 < limit_sq(still_speed_r)) begin
      if (slow_run != COUNT_MAX) slow_run = slow_run + 8'd1;
    end else begin
      slow_run = '0;
    end
    r.is_still = (slow_run >= still_frames_r);
    lim2 = limit_sq(r.is_still ? jump_still_r : jump_moving_r);
    now_pos = '{s.pos_x, s.pos_y, s.pos_z};
    old_pos = '{held.pos_x, held.pos_y, held.pos_z};
    far   = 1'b0;
    jump2 = '0;
    for (i = 0; i < 3; i++) begin
      d = longint'(now_pos[i]) - longint'(old_pos[i]);
      if (d < 0) d = -d;
      a = d;
      // an axis step of 2^31 or more beats any limit outright
      if (a >= 64'h8000_0000) far = 1'b1;
      else jump2 = jump2 + a * a;
    end
    if (jump2 > lim2) far = 1'b1;
    if (pose_held_ok && far) begin
      r.reject_status = r.reject_status | ST_JUMP;
    end else begin
      held.pos_x   = s.pos_x;
      held.pos_y   = s.pos_y;
      held.pos_z   = s.pos_z;
      held.quat_w  = s.quat_w;
      held.quat_x  = s.quat_x;
      held.quat_y  = s.quat_y;
      held.quat_z  = s.quat_z;
      pose_held_ok = 1'b1;
    end
    r.out_pos_x  = held.pos_x;
    r.out_pos_y  = held.pos_y;
    r.out_pos_z  = held.pos_z;
    r.out_quat_w = held.quat_w;
    r.out_quat_x = held.quat_x;
    r.out_quat_y = held.quat_y;
    r.out_quat_z = held.quat_z;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic compare_odom(out_item_t want, out_item_t got);
    check_field("out_vel_x", want.out_vel_x, got.out_vel_x);
    check_field("out_vel_y", want.out_vel_y, got.out_vel_y);
    check_field("out_vel_z", want.out_vel_z, got.out_vel_z);
    check_field("out_pos_x", want.out_pos_x, got.out_pos_x);
    check_field("out_pos_y", want.out_pos_y, got.out_pos_y);
    check_field("out_pos_z", want.out_pos_z, got.out_pos_z);
    check_field("out_quat_w", want.out_quat_w, got.out_quat_w);
    check_field("out_quat_x", want.out_quat_x, got.out_quat_x);
    check_field("out_quat_y", want.out_quat_y, got.out_quat_y);
    check_field("out_quat_z", want.out_quat_z, got.out_quat_z);
    check_field("reject_status", want.reject_status, got.reject_status);
    check_field("is_still", want.is_still, got.is_still);
  endtask

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      clear_watchdog();
    end else begin
      if (cfg_we) set_limit(cfg_idx, cfg_wdata);
      if (in_fire) begin
        odom_expected_q.push_back(judge_sample(in_data));
        taken_count++;
      end
      if (out_valid && !out_stall) begin
        if (odom_expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none, got %h", $time, out_data);
        end else begin
          compare_odom(odom_expected_q.pop_front(), out_data);
        end
      end
    end
  end

  // Sample driver: hold a stalled transaction, otherwise idle or advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_valid <= 1'b0;
    end else if (sample_q.size() != 0) begin
      in_data  <= sample_q.pop_front();
      in_valid <= 1'b1;
      if (idle_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 8);
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic longint rand_within(longint lim);
    if (lim <= 0) return 0;
    return longint'($urandom_range(0, lim * 2)) - lim;
  endfunction

  function automatic longint step_lim(logic [30:0] v);
    longint h;
    h = longint'(v) / 2;
    return (h > STEP_CAP) ? STEP_CAP : h;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] rand_quat();
    int q;
    if ($urandom_range(0, 1)) q = int'($urandom_range(0, 32768)) - 16384;
    else q = $urandom();
    return q[15:0];
  endfunction

  function automatic sample_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return K_CRUISE;
    if (r < 65) return K_STILL;
    if (r < 75) return K_SPIKE;
    if (r < 85) return K_JUMP;
    if (r < 94) return K_EDGE;
    return K_NOISE;
  endfunction

  function automatic in_item_t make_sample(sample_kind_e kind);
    in_item_t s;
    longint   v[3];
    longint   p[3];
    longint   sgn;
    int       ax, sub, i;
    bit       moves;
    sgn   = $urandom_range(0, 1) ? 1 : -1;
    ax    = $urandom_range(0, 2);
    moves = 1'b1;
    for (i = 0; i < 3; i++) begin
      v[i] = rand_within(longint'(max_speed_r) / 2);
      p[i] = trail[i] + rand_within(step_lim(jump_moving_r));
    end
    case (kind)
      K_STILL: begin
        for (i = 0; i < 3; i++) begin
          v[i] = rand_within(longint'(still_speed_r) / 2);
          p[i] = trail[i] + rand_within(step_lim(jump_still_r));
        end
      end
      K_SPIKE: begin
        v[ax] = sgn * (longint'(max_speed_r) + 1 + $urandom_range(0, 1 << 18));
        for (i = 0; i < 3; i++) p[i] = trail[i];
      end
      K_JUMP: begin
        moves = 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          for (i = 0; i < 3; i++) p[i] = int'($urandom());
        end else begin
          p[ax] = trail[ax] + sgn * (longint'(jump_moving_r) + 1 + $urandom_range(0, 1 << 20));
        end
      end
      K_EDGE: begin
        sub = $urandom_range(0, 3);
        for (i = 0; i < 3; i++) p[i] = trail[i];
        if (sub < 2) begin
          v = '{0, 0, 0};
          if (sub == 0) v[ax] = sgn * (longint'(max_speed_r) + $urandom_range(0, 1));
          else v[ax] = sgn * (longint'(still_speed_r) - $urandom_range(0, 1));
        end else if (sub == 2) begin
          p[ax] = trail[ax] + sgn * (longint'(jump_moving_r) + $urandom_range(0, 1));
        end else begin
          v = '{0, 0, 0};
          p[ax] = trail[ax] + sgn * (longint'(jump_still_r) + $urandom_range(0, 1));
        end
      end
      default: ;
    endcase
    s.vel_x  = clip32(v[0]);
    s.vel_y  = clip32(v[1]);
    s.vel_z  = clip32(v[2]);
    s.pos_x  = p[0][31:0];
    s.pos_y  = p[1][31:0];
    s.pos_z  = p[2][31:0];
    s.quat_w = rand_quat();
    s.quat_x = rand_quat();
    s.quat_y = rand_quat();
    s.quat_z = rand_quat();
    if (kind == K_NOISE) begin
      s = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())};
      moves = 1'b0;
    end
    if (moves) begin
      trail[0] = longint'(s.pos_x);
      trail[1] = longint'(s.pos_y);
      trail[2] = longint'(s.pos_z);
    end
    return s;
  endfunction

  task automatic push_sample(in_item_t s);
    sample_q.push_back(s);
    queued_count++;
  endtask

  task automatic put_fields(longint vx, longint vy, longint vz, longint px, longint py,
                            longint pz, int qw, int qx, int qy, int qz);
    in_item_t s;
    s = {vx[31:0], vy[31:0], vz[31:0], px[31:0], py[31:0], pz[31:0],
         qw[15:0], qx[15:0], qy[15:0], qz[15:0]};
    push_sample(s);
  endtask

  task automatic queue_random(int count);
    sample_kind_e kind;
    int           left, run, j;
    left = count;
    while (left > 0) begin
      kind = pick_kind();
      if (kind == K_STILL) run = $urandom_range(1, int'(still_frames_r) + 3);
      else if (kind == K_CRUISE) run = $urandom_range(1, 6);
      else run = 1;
      for (j = 0; j < run && left > 0; j++) begin
        push_sample(make_sample(kind));
        left--;
      end
    end
  endtask

  // Let the pipeline empty, then resync the trajectory to the held pose
  task automatic wait_drained();
    while (taken_count != queued_count || odom_expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    trail[0] = longint'(held.pos_x);
    trail[1] = longint'(held.pos_y);
    trail[2] = longint'(held.pos_z);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    trail = '{0, 0, 0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    // Default limits: boundaries of every comparison
    put_fields(327680, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
    put_fields(-327680, 0, 0, 65536, 0, 0, -16384, 16384, -16384, 16384);
    put_fields(327681, 0, 0, 131073, 0, 0, 1, 2, 3, 4);
    put_fields(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
               -64'sd2147483648, 0, 0, -16384, -16384, -16384, -16384);
    put_fields(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
               64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 0, 0, 0, 0);
    repeat (6) put_fields(0, 0, 0, 65536, 0, 0, 16384, 0, 0, 0);
    put_fields(0, 0, 0, 75366, 0, 0, 0, 16384, 0, 0);
    put_fields(0, 0, 0, 85197, 0, 0, 0, 0, 16384, 0);
    put_fields(3277, 0, 0, 85197, 0, 0, 0, 0, 0, 16384);
    put_fields(3276, 0, 0, 85197, 0, 0, 32767, -32768, 32767, -32768);
    put_fields(0, -327680, 0, 85197, -65536, 0, -32768, 32767, -32768, 32767);
    put_fields(0, 0, 327680, 85197, -65536, 65536, 16384, 0, 0, 0);
    wait_drained();

    queue_random(110);
    wait_drained();
    queue_random(110);
    wait_drained();

    idle_on = 1'b0;
    write_reg(CFG_MAX_SPEED, $urandom_range(1 << 16, 12 << 16));
    write_reg(CFG_STILL_SPEED, $urandom_range(0, 1 << 13));
    write_reg(CFG_STILL_FRAMES, $urandom_range(1, 12));
    write_reg(CFG_JUMP_MOVING, $urandom_range(1 << 14, 1 << 18));
    write_reg(CFG_JUMP_STILL, $urandom_range(0, 1 << 14));
    queue_random(90);
    idle_on = 1'b1;
    queue_random(90);
    wait_drained();

    // Widest limits: long slow run saturates the frame counter
    write_reg(CFG_MAX_SPEED, LIM_TOP);
    write_reg(CFG_STILL_SPEED, LIM_TOP);
    write_reg(CFG_STILL_FRAMES, 31'd255);
    write_reg(CFG_JUMP_MOVING, LIM_TOP);
    write_reg(CFG_JUMP_STILL, LIM_TOP);
    repeat (270) push_sample(make_sample(K_STILL));
    queue_random(20);
    wait_drained();

    // Zero limits except the moving jump limit, zero frame count, and a write to an unused index
    write_reg(CFG_MAX_SPEED, '0);
    write_reg(CFG_STILL_SPEED, '0);
    write_reg(CFG_STILL_FRAMES, '0);
    write_reg(CFG_JUMP_STILL, '0);
    write_reg(CFG_JUMP_MOVING, $urandom_range(1 << 14, 1 << 18));
    write_reg(CFG_SPARE, $urandom());
    queue_random(80);
    wait_drained();

    idle_on = 1'b0;
    write_reg(CFG_MAX_SPEED, $urandom_range(1 << 16, 12 << 16));
    write_reg(CFG_STILL_SPEED, $urandom_range(1 << 10, 1 << 14));
    write_reg(CFG_STILL_FRAMES, $urandom_range(1, 8));
    write_reg(CFG_JUMP_MOVING, $urandom_range(1 << 15, 1 << 18));
    write_reg(CFG_JUMP_STILL, $urandom_range(0, 1 << 15));
    queue_random(90);
    wait_drained();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
